@@ design/dsuf_pkg.sv @@
// shared types and constants for the disjoint-set union-find block
package dsuf_pkg;

  // default table depth
  localparam int MAX_ELEMENTS_DEF = 256;

  // field widths
  localparam int ELEM_W  = 8;
  localparam int COUNT_W = 9;
  localparam int SIZE_W  = 9;

  // element count after reset
  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

  // command codes
  typedef enum logic [1:0] {
    CMD_FIND  = 2'd0,
    CMD_UNION = 2'd1,
    CMD_SAME  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  // one result beat from the sequencer to the output stage
  typedef struct packed {
    logic [ELEM_W-1:0] root_a;
    logic [ELEM_W-1:0] root_b;
    logic              same_set;
    logic              merged;
    logic [SIZE_W-1:0] set_size;
    logic              index_error;
  } res_t;

endpackage

@@ design/dsuf_ram.sv @@
// single-port-write, single-port-read table memory with registered read data
module dsuf_ram #(
  parameter int DEPTH = dsuf_pkg::MAX_ELEMENTS_DEF,
  parameter int WIDTH = 10,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/dsuf_out.sv @@
// output register holding one result beat
module dsuf_out (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  dsuf_pkg::res_t               res,
  output logic                         push_ok,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dsuf_pkg::ELEM_W-1:0]  out_root_a,
  output logic [dsuf_pkg::ELEM_W-1:0]  out_root_b,
  output logic                         out_same_set,
  output logic                         out_merged,
  output logic [dsuf_pkg::SIZE_W-1:0]  out_set_size,
  output logic                         out_index_error
);

  logic           valid_r;
  dsuf_pkg::res_t data_r;

  // slot is free when empty or being taken this cycle
  assign push_ok = !valid_r || !out_stall;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push_ok) begin
      valid_r <= push;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (push && push_ok) begin
      data_r <= res;
    end
  end

  assign out_valid       = valid_r;
  assign out_root_a      = data_r.root_a;
  assign out_root_b      = data_r.root_b;
  assign out_same_set    = data_r.same_set;
  assign out_merged      = data_r.merged;
  assign out_set_size    = data_r.set_size;
  assign out_index_error = data_r.index_error;

endmodule

@@ design/dsuf_seq.sv @@
// command sequencer: pointer walks, path compression, linking and clearing over the table
module dsuf_seq #(
  parameter int MAX_ELEMENTS = dsuf_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [dsuf_pkg::COUNT_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_cmd,
  input  logic [dsuf_pkg::ELEM_W-1:0]   in_elem_a,
  input  logic [dsuf_pkg::ELEM_W-1:0]   in_elem_b,
  output logic                          push,
  output dsuf_pkg::res_t                res,
  input  logic                          push_ok
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  // parent index, or negated size (up to MAX_ELEMENTS) for a root
  localparam int EW = AW + 2;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_ELEMENTS - 1);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_WALK,
    S_CMP,
    S_START_B,
    S_FIN,
    S_LINK_BIG,
    S_LINK_SMALL,
    S_DONE
  } state_t;

  // root index to output field width
  function automatic logic [dsuf_pkg::ELEM_W-1:0] to_elem(input logic [AW-1:0] r);
    logic [AW+dsuf_pkg::ELEM_W-1:0] e;
    e = {{dsuf_pkg::ELEM_W{1'b0}}, r};
    return e[dsuf_pkg::ELEM_W-1:0];
  endfunction

  // negated root value to set size field
  function automatic logic [dsuf_pkg::SIZE_W-1:0] to_size(input logic [EW-1:0] v);
    logic [EW-1:0]                  neg;
    logic [AW+dsuf_pkg::SIZE_W:0]   e;
    neg = -v;
    e   = {{dsuf_pkg::SIZE_W{1'b0}}, neg[AW:0]};
    return e[dsuf_pkg::SIZE_W-1:0];
  endfunction

  state_t                       state_r, state_nxt;
  dsuf_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [dsuf_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [AW-1:0]                b_idx_r, b_idx_nxt;
  logic [AW-1:0]                x_r, x_nxt;
  logic [AW-1:0]                cur_r, cur_nxt;
  logic [AW-1:0]                ra_r, ra_nxt;
  logic [AW-1:0]                rb_r, rb_nxt;
  logic [EW-1:0]                va_r, va_nxt;
  logic [EW-1:0]                vb_r, vb_nxt;
  logic                         phase_b_r, phase_b_nxt;
  logic [AW-1:0]                clr_cnt_r, clr_cnt_nxt;
  logic                         clr_cmd_r, clr_cmd_nxt;
  dsuf_pkg::res_t               res_r, res_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic [AW+dsuf_pkg::ELEM_W-1:0] a_ext, b_ext;
  logic [AW-1:0]                  a_idx, b_idx;
  logic                           a_bad, b_bad, in_err;
  dsuf_pkg::cmd_t                 in_cmd_c;
  logic [AW-1:0]                  par_idx, root_cur;
  logic                           big_is_b;
  logic [AW-1:0]                  big_idx, small_idx;
  logic [EW-1:0]                  sum_v;

  dsuf_ram #(
    .DEPTH (MAX_ELEMENTS),
    .WIDTH (EW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // input index decode and range check
  assign in_cmd_c = dsuf_pkg::cmd_t'(in_cmd);
  assign a_ext    = {{AW{1'b0}}, in_elem_a};
  assign b_ext    = {{AW{1'b0}}, in_elem_b};
  assign a_idx    = a_ext[AW-1:0];
  assign b_idx    = b_ext[AW-1:0];
  assign a_bad    = ({1'b0, in_elem_a} >= count_r) || (32'(in_elem_a) >= MAX_ELEMENTS);
  assign b_bad    = ({1'b0, in_elem_b} >= count_r) || (32'(in_elem_b) >= MAX_ELEMENTS);
  assign in_err   = a_bad || ((in_cmd_c != dsuf_pkg::CMD_FIND) && b_bad);

  // walk helpers
  assign par_idx  = ram_rdata[AW-1:0];
  assign root_cur = phase_b_r ? rb_r : ra_r;

  // link choice: the larger set stays root, a wins a tie
  assign big_is_b  = $signed(vb_r) < $signed(va_r);
  assign big_idx   = big_is_b ? rb_r : ra_r;
  assign small_idx = big_is_b ? ra_r : rb_r;
  assign sum_v     = va_r + vb_r;

  assign in_stall = (state_r != S_IDLE);
  assign push     = (state_r == S_DONE) && push_ok;
  assign res      = res_r;

  // sequencer next state
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    count_nxt   = count_r;
    b_idx_nxt   = b_idx_r;
    x_nxt       = x_r;
    cur_nxt     = cur_r;
    ra_nxt      = ra_r;
    rb_nxt      = rb_r;
    va_nxt      = va_r;
    vb_nxt      = vb_r;
    phase_b_nxt = phase_b_r;
    clr_cnt_nxt = clr_cnt_r;
    clr_cmd_nxt = clr_cmd_r;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_waddr   = cur_r;
    ram_wdata   = {{(EW-AW){1'b0}}, root_cur};
    ram_re      = 1'b0;
    ram_raddr   = cur_r;

    if (cfg_wr_en) begin
      count_nxt = cfg_wr_data;
    end

    case (state_r)
      // sweep every entry back to a singleton
      S_CLR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_IDX) begin
          clr_cnt_nxt = '0;
          if (clr_cmd_r) begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      // take a command beat
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = in_cmd_c;
          b_idx_nxt   = b_idx;
          x_nxt       = a_idx;
          cur_nxt     = a_idx;
          phase_b_nxt = 1'b0;
          if (in_cmd_c == dsuf_pkg::CMD_CLEAR) begin
            clr_cmd_nxt = 1'b1;
            clr_cnt_nxt = '0;
            state_nxt   = S_CLR;
          end else if (in_err) begin
            res_nxt             = '0;
            res_nxt.index_error = 1'b1;
            state_nxt           = S_DONE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = a_idx;
            state_nxt = S_WALK;
          end
        end
      end

      // follow parent pointers up to the root
      S_WALK: begin
        if (!ram_rdata[EW-1]) begin
          cur_nxt   = par_idx;
          ram_re    = 1'b1;
          ram_raddr = par_idx;
        end else begin
          if (phase_b_r) begin
            rb_nxt = cur_r;
            vb_nxt = ram_rdata;
          end else begin
            ra_nxt = cur_r;
            va_nxt = ram_rdata;
          end
          if (x_r == cur_r) begin
            state_nxt = (phase_b_r || cmd_r == dsuf_pkg::CMD_FIND) ? S_FIN : S_START_B;
          end else begin
            cur_nxt   = x_r;
            ram_re    = 1'b1;
            ram_raddr = x_r;
            state_nxt = S_CMP;
          end
        end
      end

      // second walk: point each entry on the path at the root
      S_CMP: begin
        if (!ram_rdata[EW-1]) begin
          ram_we = 1'b1;
          if (par_idx == root_cur) begin
            state_nxt = (phase_b_r || cmd_r == dsuf_pkg::CMD_FIND) ? S_FIN : S_START_B;
          end else begin
            cur_nxt   = par_idx;
            ram_re    = 1'b1;
            ram_raddr = par_idx;
          end
        end else begin
          state_nxt = (phase_b_r || cmd_r == dsuf_pkg::CMD_FIND) ? S_FIN : S_START_B;
        end
      end

      // begin the find of b once the last write of a has landed
      S_START_B: begin
        phase_b_nxt = 1'b1;
        x_nxt       = b_idx_r;
        cur_nxt     = b_idx_r;
        ram_re      = 1'b1;
        ram_raddr   = b_idx_r;
        state_nxt   = S_WALK;
      end

      // compare roots, build the result or go link
      S_FIN: begin
        res_nxt        = '0;
        res_nxt.root_a = to_elem(ra_r);
        res_nxt.set_size = to_size(va_r);
        if (cmd_r != dsuf_pkg::CMD_FIND) begin
          res_nxt.root_b   = to_elem(rb_r);
          res_nxt.same_set = (ra_r == rb_r);
        end
        if (cmd_r == dsuf_pkg::CMD_UNION && ra_r != rb_r) begin
          state_nxt = S_LINK_BIG;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // grow the surviving root
      S_LINK_BIG: begin
        ram_we    = 1'b1;
        ram_waddr = big_idx;
        ram_wdata = sum_v;
        state_nxt = S_LINK_SMALL;
      end

      // hang the other root under it
      S_LINK_SMALL: begin
        ram_we           = 1'b1;
        ram_waddr        = small_idx;
        ram_wdata        = {{(EW-AW){1'b0}}, big_idx};
        res_nxt.root_a   = to_elem(big_idx);
        res_nxt.merged   = 1'b1;
        res_nxt.set_size = to_size(sum_v);
        state_nxt        = S_DONE;
      end

      // hand the result beat over
      S_DONE: begin
        if (push_ok) begin
          clr_cmd_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      count_r   <= dsuf_pkg::COUNT_RESET;
      clr_cnt_r <= '0;
      clr_cmd_r <= 1'b0;
      phase_b_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      clr_cmd_r <= clr_cmd_nxt;
      phase_b_r <= phase_b_nxt;
    end
    cmd_r   <= cmd_nxt;
    b_idx_r <= b_idx_nxt;
    x_r     <= x_nxt;
    cur_r   <= cur_nxt;
    ra_r    <= ra_nxt;
    rb_r    <= rb_nxt;
    va_r    <= va_nxt;
    vb_r    <= vb_nxt;
    res_r   <= res_nxt;
  end

  // a compression write never targets the entry being read in the same cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("table read and write hit the same entry");

  // a merge only follows two distinct, in-range roots
  a_merge_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.merged) |-> (!res.same_set && !res.index_error))
    else $error("merge reported on same set or rejected index");

  // a rejected beat leaves every other field clear
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.index_error) |-> (res.set_size == '0 && !res.merged && res.root_a == '0))
    else $error("rejected beat carries result data");

  // a valid find reports a non-empty set
  a_find_size: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && cmd_r == dsuf_pkg::CMD_FIND) |=> (res_r.set_size != '0))
    else $error("find returned an empty set");

endmodule

@@ design/disjoint_set_union_find.sv @@
// top level of the disjoint-set union-find block (union by size, path compression)
//
//  channel  direction  handshake            beat contents
//  in_      input      in_valid / in_stall   in_cmd, in_elem_a, in_elem_b
//  out_     output     out_valid / out_stall out_root_a, out_root_b, out_same_set,
//                                            out_merged, out_set_size, out_index_error
//  cfg_     input      cfg_wr_en             cfg_wr_data (element_count)
//
// one command at a time; each pointer hop of a find waits on the registered read of
// the table memory. union and same-set run two finds back to back; a union adds two
// link writes when the roots differ. clear and reset both sweep the table one entry
// a cycle, with in_stall high throughout. a rejected index skips the table walk.
// the output register lets the next command run while a result waits; a second
// result waits for out_stall to drop.
module disjoint_set_union_find #(
  parameter int MAX_ELEMENTS = dsuf_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [dsuf_pkg::COUNT_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_cmd,
  input  logic [dsuf_pkg::ELEM_W-1:0]   in_elem_a,
  input  logic [dsuf_pkg::ELEM_W-1:0]   in_elem_b,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dsuf_pkg::ELEM_W-1:0]   out_root_a,
  output logic [dsuf_pkg::ELEM_W-1:0]   out_root_b,
  output logic                          out_same_set,
  output logic                          out_merged,
  output logic [dsuf_pkg::SIZE_W-1:0]   out_set_size,
  output logic                          out_index_error
);

  logic           push;
  logic           push_ok;
  dsuf_pkg::res_t res;

  // command sequencer with the table memory
  dsuf_seq #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_elem_a   (in_elem_a),
    .in_elem_b   (in_elem_b),
    .push        (push),
    .res         (res),
    .push_ok     (push_ok)
  );

  // result register
  dsuf_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .res             (res),
    .push_ok         (push_ok),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_root_a      (out_root_a),
    .out_root_b      (out_root_b),
    .out_same_set    (out_same_set),
    .out_merged      (out_merged),
    .out_set_size    (out_set_size),
    .out_index_error (out_index_error)
  );

endmodule
